>>> rtl/asddc_pkg.sv
// Package for the addressed serial digit display controller.
// Holds the payload structs, codes, state enums and the glyph table.
// No dependencies.
package asddc_pkg;

  localparam int NUM_DIGITS   = 10;
  localparam int NUM_PATTERNS = 17;
  localparam int IDX_W        = 4;
  localparam int VAL_W        = 5;

  localparam logic [7:0] START_CODE = 8'hF0;
  localparam logic [7:0] SET_CODE   = 8'h31;
  localparam logic [7:0] CLEAR_CODE = 8'h32;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  localparam logic [VAL_W-1:0] BLANK_VALUE = VAL_W'(10);
  localparam logic [VAL_W-1:0] MAX_IDLE    = VAL_W'(31);
  localparam logic [VAL_W-1:0] LAST_PATTERN = VAL_W'(NUM_PATTERNS - 1);
  localparam logic [IDX_W-1:0] LAST_INDEX  = IDX_W'(NUM_DIGITS - 1);

  localparam logic [7:0]       OWN_ADDRESS_RESET = 8'd52;
  localparam logic [VAL_W-1:0] IDLE_LIMIT_RESET  = VAL_W'(20);

  // configuration register indexes
  localparam logic CFG_OWN_ADDRESS = 1'b0;
  localparam logic CFG_IDLE_LIMIT  = 1'b1;

  localparam logic [31:0] S_DN = 32'h1000_0000;
  localparam logic [31:0] S_DR = 32'h2000_0000;
  localparam logic [31:0] S_DL = 32'h0800_0000;
  localparam logic [31:0] S_CE = 32'h0200_0000;
  localparam logic [31:0] S_UR = 32'h4000_0000;
  localparam logic [31:0] S_UL = 32'h0400_0000;
  localparam logic [31:0] S_UP = 32'h8000_0000;
  localparam logic [31:0] DOT_BITS = 32'h0100_0008;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  digit_index;
    logic [31:0] segment_pattern;
    logic        last_digit;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } ctrl_state_t;

  typedef enum logic [2:0] {
    PH_START,
    PH_ADDR,
    PH_CMD,
    PH_DIGIT,
    PH_VALUE
  } frame_phase_t;

  typedef struct packed {
    logic byte_en;
    logic tick_en;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    logic is_last;
  } dp_status_t;

  function automatic logic [31:0] b32(input int n);
    b32 = 32'(1) << n;
  endfunction

  function automatic logic [VAL_W-1:0] start_value(input int i);
    case (i)
      0: start_value = VAL_W'(3);
      1: start_value = VAL_W'(11);
      2: start_value = VAL_W'(12);
      3: start_value = VAL_W'(13);
      4: start_value = VAL_W'(14);
      5: start_value = VAL_W'(15);
      6: start_value = VAL_W'(16);
      default: start_value = BLANK_VALUE;
    endcase
  endfunction

  function automatic logic [31:0] glyph(input logic [VAL_W-1:0] v);
    case (v)
      5'd0: glyph = S_UP|S_UL|S_UR|S_DL|S_DR|S_DN|b32(5)|b32(8)|b32(11)|b32(12)|b32(14)
                    |b32(15)|b32(18)|b32(21)|b32(23);
      5'd1: glyph = S_UR|S_DR|b32(4)|b32(5)|b32(6)|b32(7)|b32(8)|b32(9)|b32(10)|b32(11)
                    |b32(12)|b32(14)|b32(18);
      5'd2: glyph = S_UP|S_UR|S_CE|S_DL|S_DN|b32(6)|b32(7)|b32(9)|b32(12)|b32(13)|b32(17)
                    |b32(19)|b32(20)|b32(21)|b32(23);
      5'd3: glyph = S_UP|S_UR|S_CE|S_DR|S_DN|b32(7)|b32(9)|b32(14)|b32(15)|b32(16)|b32(18)
                    |b32(19)|b32(20)|b32(21)|b32(23);
      5'd4: glyph = S_UL|S_UR|S_CE|S_DR|b32(7)|b32(9)|b32(10)|b32(11)|b32(12)|b32(14)
                    |b32(16)|b32(18)|b32(19)|b32(20);
      5'd5: glyph = S_UP|S_UL|S_CE|S_DR|S_DN|b32(5)|b32(7)|b32(9)|b32(10)|b32(14)|b32(15)
                    |b32(16)|b32(17)|b32(19)|b32(21);
      5'd6: glyph = S_UL|S_CE|S_DL|S_DR|S_DN|b32(6)|b32(8)|b32(9)|b32(10)|b32(12)|b32(14)
                    |b32(15)|b32(16)|b32(17)|b32(19)|b32(21)|b32(22)|b32(23);
      5'd7: glyph = S_UP|S_UR|S_DR|b32(6)|b32(7)|b32(8)|b32(9)|b32(10)|b32(11)|b32(12)
                    |b32(14)|b32(18)|b32(23);
      5'd8: glyph = S_UP|S_UL|S_UR|S_CE|S_DL|S_DR|S_DN|b32(5)|b32(6)|b32(8)|b32(9)|b32(10)
                    |b32(12)|b32(14)|b32(15)|b32(16)|b32(18)|b32(19)|b32(20)|b32(21)
                    |b32(23);
      5'd9: glyph = S_UP|S_UL|S_UR|S_CE|S_DR|S_DN|b32(5)|b32(7)|b32(9)|b32(10)|b32(14)
                    |b32(15)|b32(16)|b32(18)|b32(19)|b32(20)|b32(21)|b32(23);
      5'd10: glyph = b32(4)|b32(5)|b32(6)|b32(7)|b32(8)|b32(9)|b32(10)|b32(11)|b32(12)
                     |b32(13)|b32(14)|b32(15)|b32(16)|b32(17)|b32(18)|b32(19)|b32(20)
                     |b32(21)|b32(22)|b32(23);
      5'd11: glyph = S_UP|S_UL|S_UR|S_CE|S_DL|S_DR|b32(5)|b32(6)|b32(8)|b32(9)|b32(10)
                     |b32(13)|b32(16)|b32(18)|b32(19)|b32(20)|b32(21)|b32(23);
      5'd12: glyph = S_UP|S_UL|S_UR|S_CE|S_DL|S_DR|S_DN|b32(8)|b32(9)|b32(13)|b32(15)
                     |b32(17)|b32(18)|b32(21)|b32(23);
      5'd13: glyph = S_UP|S_UL|S_DL|S_DN|b32(5)|b32(8)|b32(12)|b32(13)|b32(16)|b32(17)
                     |b32(18)|b32(19)|b32(20)|b32(21);
      5'd14: glyph = S_UP|S_UL|S_UR|S_DL|S_DR|S_DN|b32(8)|b32(13)|b32(15)|b32(18)|b32(21)
                     |b32(23);
      5'd15: glyph = S_UP|S_UL|S_CE|S_DL|S_DN|b32(5)|b32(6)|b32(8)|b32(9)|b32(10)|b32(12)
                     |b32(13)|b32(16)|b32(17)|b32(18)|b32(20)|b32(21);
      5'd16: glyph = S_UP|S_UL|S_CE|S_DL|b32(5)|b32(6)|b32(8)|b32(9)|b32(10)|b32(13)
                     |b32(14)|b32(15)|b32(16)|b32(17)|b32(18)|b32(20)|b32(21);
      default: glyph = 32'h0;
    endcase
  endfunction

endpackage

>>> rtl/addressed_serial_digit_display_ctrl.sv
// Top level of the addressed serial digit display controller.
// Joins asddc_ctrl and asddc_datapath; depends on asddc_pkg.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   in_item_t  (operation, rx_byte)
//   out      output     out_valid / out_stall out_item_t (digit_index, segment_pattern,
//                                                         last_digit)
//   cfg      input      cfg_we                cfg_index, cfg_data
//
// A byte transaction yields no result.
// A tick transaction yields ten results from the digit run counter, one per cycle while
// out_stall is low; the next transaction is taken in the cycle the last digit leaves, so
// back-to-back ticks run with no gap between runs when out_stall stays low.
// out_stall holds the run on the current digit; in_stall is high during a run.
// rst (synchronous) restores the register defaults and the start-up digits.
module addressed_serial_digit_display_ctrl import asddc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  asddc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (in_data.operation),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  asddc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx_byte   (in_data.rx_byte),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

>>> rtl/asddc_ctrl.sv
// Controller state machine: accepts transactions and sequences the digit run.
// Depends on asddc_pkg.
module asddc_ctrl import asddc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       operation,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;
  logic        run_done;
  logic        accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // outputs
  always_comb begin
    out_valid   = (state == ST_EMIT);
    cmd.advance = (state == ST_EMIT) && !out_stall;
    run_done    = cmd.advance && status.is_last;
    // take the next transaction while the last digit leaves
    in_stall    = !((state == ST_IDLE) || run_done);
    accept      = in_valid && !in_stall;
    cmd.byte_en = accept && !operation;
    cmd.tick_en = accept && operation;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.tick_en) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (run_done && !cmd.tick_en) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/asddc_datapath.sv
// Datapath: config registers, frame parser registers, digit values,
// idle/demo counters and the pattern lookup. Depends on asddc_pkg.
module asddc_datapath import asddc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic [7:0] rx_byte,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output out_item_t  out_data
);

  logic [7:0]       own_address;
  logic [VAL_W-1:0] idle_limit;
  frame_phase_t     frame_phase;
  logic [7:0]       frame_address;
  logic [7:0]       frame_command;
  logic [7:0]       frame_digit_char;
  logic [VAL_W-1:0] digit_values [NUM_DIGITS];
  logic [VAL_W-1:0] idle_ticks;
  logic [VAL_W-1:0] demo_value;
  logic [VAL_W-1:0] demo_value_next;
  logic [IDX_W-1:0] idx;

  logic [7:0]       pos;
  logic [7:0]       val;
  logic             frame_hit;
  logic             set_ok;
  logic             do_clear;
  logic             demo_on;
  logic [VAL_W-1:0] cur_value;

  always_comb begin
    pos       = frame_digit_char - CHAR_ZERO;
    val       = rx_byte - CHAR_ZERO;
    frame_hit = cmd.byte_en && (frame_phase == PH_VALUE) && (frame_address == own_address);
    set_ok    = frame_hit && (frame_command == SET_CODE) &&
                (pos < 8'(NUM_DIGITS)) && (val < 8'(NUM_PATTERNS));
    do_clear  = frame_hit && (frame_command == CLEAR_CODE);
    demo_on   = cmd.tick_en && (idle_ticks > idle_limit);
    demo_value_next = (demo_value >= LAST_PATTERN) ? '0 : demo_value + VAL_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= OWN_ADDRESS_RESET;
      idle_limit  <= IDLE_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OWN_ADDRESS: own_address <= cfg_data;
        CFG_IDLE_LIMIT:  idle_limit  <= cfg_data[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // frame parser
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_phase      <= PH_START;
      frame_address    <= '0;
      frame_command    <= '0;
      frame_digit_char <= '0;
    end else if (cmd.byte_en) begin
      case (frame_phase)
        PH_ADDR: begin
          frame_address <= rx_byte;
          frame_phase   <= PH_CMD;
        end
        PH_CMD: begin
          frame_command <= rx_byte;
          frame_phase   <= PH_DIGIT;
        end
        PH_DIGIT: begin
          frame_digit_char <= rx_byte;
          frame_phase      <= PH_VALUE;
        end
        PH_VALUE: frame_phase <= PH_START;
        default:  frame_phase <= (rx_byte == START_CODE) ? PH_ADDR : PH_START;
      endcase
    end
  end

  // idle count and demo counter
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_ticks <= '0;
      demo_value <= '0;
    end else if (frame_hit) begin
      idle_ticks <= '0;
    end else if (demo_on) begin
      demo_value <= demo_value_next;
    end else if (cmd.tick_en && idle_ticks != MAX_IDLE) begin
      idle_ticks <= idle_ticks + VAL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DIGITS; i++) digit_values[i] <= start_value(i);
    end else if (demo_on) begin
      for (int i = 0; i < NUM_DIGITS; i++) digit_values[i] <= demo_value_next;
    end else if (do_clear) begin
      for (int i = 0; i < NUM_DIGITS; i++) digit_values[i] <= BLANK_VALUE;
    end else if (set_ok) begin
      digit_values[pos[IDX_W-1:0]] <= val[VAL_W-1:0];
    end
  end

  // digit run counter
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.advance) begin
      idx <= (idx == LAST_INDEX) ? '0 : idx + IDX_W'(1);
    end
  end

  always_comb begin
    cur_value                = digit_values[idx];
    status.is_last           = (idx == LAST_INDEX);
    out_data.digit_index     = idx;
    out_data.segment_pattern = glyph(cur_value) |
                               ((cur_value != BLANK_VALUE) ? DOT_BITS : 32'h0);
    out_data.last_digit      = status.is_last;
  end

endmodule

>>> bench/addressed_serial_digit_display_ctrl_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for addressed_serial_digit_display_ctrl: frame parsing, refresh
// ticks, idle/demo cycling and the digit patterns, under random sender gaps and stalls.
// Depends on asddc_pkg and the RTL of the block.
module addressed_serial_digit_display_ctrl_tb;
  import asddc_pkg::*;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;
  localparam int QUIET_LIMIT = 2000;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC,
    STALL_LONG
  } stall_mode_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_we = 1'b0;
  logic       cfg_index = 1'b0;
  logic [7:0] cfg_data = 8'h00;

  // bytes and ticks waiting to be sent, and digit patterns waiting to come back
  in_item_t  rx_feed[$];
  out_item_t expected_digits[$];
  out_item_t want;

  // display state as the bench predicts it
  logic [7:0]   my_address;
  logic [4:0]   my_idle_limit;
  frame_phase_t frm_phase;
  logic [7:0]   frm_addr;
  logic [7:0]   frm_cmd;
  logic [7:0]   frm_digit;
  logic [4:0]   disp_digits [NUM_DIGITS];
  logic [4:0]   idle_count;
  logic [4:0]   demo_digit;

  int error_count = 0;
  int quiet_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_left = 0;
  int beat = 0;
  stall_mode_t stall_mode = STALL_NONE;

  addressed_serial_digit_display_ctrl uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] glyph_bits(input logic [4:0] v);
    case (v)
      5'd0:    glyph_bits = 32'hFCA4D920;
      5'd1:    glyph_bits = 32'h60045FF0;
      5'd2:    glyph_bits = 32'hDABA32C0;
      5'd3:    glyph_bits = 32'hF2BDC280;
      5'd4:    glyph_bits = 32'h661D5E80;
      5'd5:    glyph_bits = 32'hB62BC6A0;
      5'd6:    glyph_bits = 32'h3EEBD740;
      5'd7:    glyph_bits = 32'hE0845FC0;
      5'd8:    glyph_bits = 32'hFEBDD760;
      5'd9:    glyph_bits = 32'hF6BDC6A0;
      5'd10:   glyph_bits = 32'h00FFFFF0;
      5'd11:   glyph_bits = 32'hEEBD2760;
      5'd12:   glyph_bits = 32'hFEA6A300;
      5'd13:   glyph_bits = 32'h9C3F3120;
      5'd14:   glyph_bits = 32'hFCA4A100;
      5'd15:   glyph_bits = 32'h9E373760;
      5'd16:   glyph_bits = 32'h8E37E760;
      default: glyph_bits = 32'h0;
    endcase
  endfunction

  task automatic flag_error(input string what);
    if (error_count < 100)
      $display("ERROR at %0t: %s", $time, what);
    error_count++;
  endtask

  // Advance the predicted display by one accepted transaction.
  task automatic apply_item(input in_item_t item);
    logic [7:0]  pos;
    logic [7:0]  val;
    logic [4:0]  v;
    logic [31:0] pat;
    if (item.operation == OP_BYTE) begin
      case (frm_phase)
        PH_ADDR: begin
          frm_addr = item.rx_byte;
          frm_phase = PH_CMD;
        end
        PH_CMD: begin
          frm_cmd = item.rx_byte;
          frm_phase = PH_DIGIT;
        end
        PH_DIGIT: begin
          frm_digit = item.rx_byte;
          frm_phase = PH_VALUE;
        end
        PH_VALUE: begin
          // foreign frames are dropped without touching the idle count
          if (frm_addr == my_address) begin
            if (frm_cmd == SET_CODE) begin
              pos = frm_digit - CHAR_ZERO;
              val = item.rx_byte - CHAR_ZERO;
              if (pos < NUM_DIGITS && val < NUM_PATTERNS)
                disp_digits[pos] = val[4:0];
            end else if (frm_cmd == CLEAR_CODE) begin
              for (int i = 0; i < NUM_DIGITS; i++)
                disp_digits[i] = BLANK_VALUE;
            end
            idle_count = '0;
          end
          frm_phase = PH_START;
        end
        default: frm_phase = (item.rx_byte == START_CODE) ? PH_ADDR : PH_START;
      endcase
    end else begin
      if (idle_count > my_idle_limit) begin
        demo_digit = (demo_digit == LAST_PATTERN) ? '0 : demo_digit + 5'd1;
        for (int i = 0; i < NUM_DIGITS; i++)
          disp_digits[i] = demo_digit;
      end else if (idle_count != MAX_IDLE) begin
        idle_count = idle_count + 5'd1;
      end
      for (int i = 0; i < NUM_DIGITS; i++) begin
        v = disp_digits[i];
        pat = glyph_bits(v);
        if (v != BLANK_VALUE)
          pat = pat | DOT_BITS;
        expected_digits.push_back(out_item_t'{digit_index: 4'(i), segment_pattern: pat,
                                              last_digit: (i == NUM_DIGITS - 1)});
      end
    end
  endtask

  task automatic queue_byte(input logic [7:0] b);
    rx_feed.push_back(in_item_t'{operation: OP_BYTE, rx_byte: b});
  endtask

  task automatic queue_tick(input logic [7:0] junk);
    rx_feed.push_back(in_item_t'{operation: OP_TICK, rx_byte: junk});
  endtask

  task automatic queue_frame(input logic [7:0] addr, input logic [7:0] cmd,
                             input logic [7:0] dch, input logic [7:0] vch);
    queue_byte(START_CODE);
    queue_byte(addr);
    queue_byte(cmd);
    queue_byte(dch);
    queue_byte(vch);
  endtask

  // Mostly well-formed frames with random content, plus ticks, stray bytes and cut frames.
  task automatic queue_traffic(input int count, input int tick_pct);
    int n;
    int pick;
    int k;
    logic [7:0] addr;
    logic [7:0] cmd;
    logic [7:0] dch;
    logic [7:0] vch;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(0, 99);
      if (pick < tick_pct) begin
        queue_tick(8'($urandom_range(0, 255)));
        n++;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          addr = ($urandom_range(0, 3) != 0) ? my_address : 8'($urandom_range(0, 255));
          pick = $urandom_range(0, 9);
          cmd = (pick < 6) ? SET_CODE : (pick < 7) ? CLEAR_CODE : 8'($urandom_range(0, 255));
          dch = ($urandom_range(0, 7) != 0) ? CHAR_ZERO + 8'($urandom_range(0, 11))
                                            : 8'($urandom_range(0, 255));
          vch = ($urandom_range(0, 7) != 0) ? CHAR_ZERO + 8'($urandom_range(0, 18))
                                            : 8'($urandom_range(0, 255));
          queue_frame(addr, cmd, dch, vch);
          n += 5;
        end else if (pick < 9) begin
          queue_byte(8'($urandom_range(0, 255)));
          n++;
        end else begin
          queue_byte(START_CODE);
          k = $urandom_range(1, 3);
          repeat (k) queue_byte(8'($urandom_range(0, 255)));
          n += k + 1;
        end
      end
    end
  endtask

  // Hold off until everything sent has been answered and the block has gone quiet.
  task automatic wait_quiet();
    do @(negedge clk);
    while (rx_feed.size() != 0 || in_valid || expected_digits.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_OWN_ADDRESS)
      my_address = value;
    else
      my_idle_limit = value[4:0];
  endtask

  initial begin
    my_address = OWN_ADDRESS_RESET;
    my_idle_limit = IDLE_LIMIT_RESET;
    frm_phase = PH_START;
    frm_addr = '0;
    frm_cmd = '0;
    frm_digit = '0;
    disp_digits = '{5'd3, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16,
                    BLANK_VALUE, BLANK_VALUE, BLANK_VALUE};
    idle_count = '0;
    demo_digit = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // start-up digits first, then set the top digit to the last table entry
    queue_tick(8'h00);
    queue_frame(OWN_ADDRESS_RESET, SET_CODE, CHAR_ZERO + 8'd9, CHAR_ZERO + 8'd16);
    // value one past the table: no digit changes
    queue_frame(OWN_ADDRESS_RESET, SET_CODE, CHAR_ZERO, CHAR_ZERO + 8'd17);
    // clear addressed to someone else: dropped
    queue_frame(OWN_ADDRESS_RESET + 8'd1, CLEAR_CODE, CHAR_ZERO, CHAR_ZERO);
    queue_tick(8'hFF);
    // clear blanks every digit
    queue_frame(OWN_ADDRESS_RESET, CLEAR_CODE, 8'hFF, 8'h00);
    queue_tick(8'h5A);
    queue_traffic(15, 30);
    wait_quiet();

    // demo cycling right away, long enough to wrap the counter
    write_reg(CFG_OWN_ADDRESS, 8'h00);
    write_reg(CFG_IDLE_LIMIT, 8'd0);
    repeat (20) queue_tick(8'($urandom_range(0, 255)));
    queue_traffic(8, 60);
    wait_quiet();

    write_reg(CFG_OWN_ADDRESS, 8'hFF);
    write_reg(CFG_IDLE_LIMIT, 8'd30);
    repeat (33) queue_tick(8'($urandom_range(0, 255)));
    queue_traffic(8, 40);
    wait_quiet();

    // idle count saturates and demo never starts
    write_reg(CFG_OWN_ADDRESS, 8'hA5);
    write_reg(CFG_IDLE_LIMIT, 8'd31);
    repeat (36) queue_tick(8'($urandom_range(0, 255)));
    queue_traffic(8, 40);
    wait_quiet();

    write_reg(CFG_OWN_ADDRESS, 8'h5A);
    write_reg(CFG_IDLE_LIMIT, 8'd3);
    queue_traffic(15, 40);
    wait_quiet();

    repeat (20) @(negedge clk);
    if (error_count == 0)
      $display("addressed_serial_digit_display_ctrl test passed");
    else
      $display("addressed_serial_digit_display_ctrl test failed");
    $finish;
  end

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (rx_feed.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= rx_feed.pop_front();
        if (burst_left <= 1) begin
          burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 10);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: switch between stall behaviors, each held for a random stretch.
  always @(posedge clk) begin
    beat <= beat + 1;
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
      STALL_PERIODIC: out_stall <= (beat % 7 < 3);
      default:        out_stall <= ($urandom_range(0, 15) == 0) ? ~out_stall : out_stall;
    endcase
  end

  // Predict on every accepted input, then check every accepted result.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        apply_item(in_data);
      if (out_valid && !out_stall) begin
        if (expected_digits.size() == 0) begin
          flag_error($sformatf("unexpected result for digit %0d", out_data.digit_index));
        end else begin
          want = expected_digits.pop_front();
          if (out_data.digit_index !== want.digit_index)
            flag_error($sformatf("digit_index %0d, want %0d",
                                 out_data.digit_index, want.digit_index));
          if (out_data.segment_pattern !== want.segment_pattern)
            flag_error($sformatf("digit %0d segment_pattern %h, want %h", want.digit_index,
                                 out_data.segment_pattern, want.segment_pattern));
          if (out_data.last_digit !== want.last_digit)
            flag_error($sformatf("digit %0d last_digit %b, want %b", want.digit_index,
                                 out_data.last_digit, want.last_digit));
        end
      end
    end
  end

  // Drop out if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("addressed_serial_digit_display_ctrl test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
